/* src/lzc_pkg.sv */
// Shared types and constants of the hashed 12-bit LZW compressor.
// Holds controller states, controller/datapath command and status bundles, tables.
// No dependencies.
`default_nettype none

package lzc_pkg;

  localparam int unsigned CODE_W     = 12;
  localparam int unsigned HASH_DEPTH = 5120;
  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned WORD_W     = TAG_W + 32;
  localparam int unsigned ACC_W      = 19;
  localparam int unsigned CNT_W      = 5;

  localparam logic [ADDR_W-1:0] PROBE_MOD  = 13'h13FF;
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(HASH_DEPTH - 1);
  localparam logic [CODE_W-1:0] DICT_RESET_CODE = 12'h100;
  localparam logic [12:0]       FIRST_FREE = 13'h101;
  localparam logic [3:0]        INIT_WIDTH = 4'd9;
  localparam logic [3:0]        MAX_WIDTH  = 4'd12;
  localparam logic [TAG_W-1:0]  TAG_FIRST  = 8'd1;
  localparam logic [TAG_W-1:0]  TAG_LAST   = 8'hFF;

  localparam logic [1:0] HDR_MAGIC0 = 2'd0;
  localparam logic [1:0] HDR_MAGIC1 = 2'd1;
  localparam logic [1:0] HDR_FLAGS  = 2'd2;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HDR,
    ST_PROBE,
    ST_PUT_PREFIX,
    ST_UPDATE,
    ST_PUT_CLEAR,
    ST_PAD,
    ST_FINAL,
    ST_FLUSH,
    ST_DRAIN
  } lzc_state_t;

  typedef enum logic {
    CODE_PREFIX,
    CODE_CLEAR
  } code_sel_t;

  typedef struct packed {
    logic      accept;
    logic      emit_hdr;
    logic [1:0] hdr_sel;
    logic      probe_step;
    logic      take_code;
    logic      put_code;
    code_sel_t code_sel;
    logic      miss_update;
    logic      pad_step;
    logic      clear_dict;
    logic      take_byte;
    logic      msg_reset;
    logic      drain;
    logic      fin_mode;
    logic      flush;
    logic      sweep;
  } lzc_cmd_t;

  typedef struct packed {
    logic started;
    logic last;
    logic hit;
    logic miss;
    logic acc_full;
    logic acc_empty;
    logic out_free;
    logic pad_done;
    logic dict_full;
    logic epoch_wrap;
    logic sweep_last;
  } lzc_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      HDR_MAGIC0: b = 8'h1F;
      HDR_MAGIC1: b = 8'h9D;
      HDR_FLAGS:  b = 8'h8C;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] pad_bits(input logic [2:0] sel);
    logic [6:0] n;
    unique case (sel)
      3'd0: n = 7'h00;
      3'd1: n = 7'h3C;
      3'd2: n = 7'h18;
      3'd3: n = 7'h54;
      3'd4: n = 7'h30;
      3'd5: n = 7'h0C;
      3'd6: n = 7'h48;
      3'd7: n = 7'h24;
      default: n = 7'h00;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* src/lzc_ifs.sv */
// Valid/ready channel interfaces of the compressor: raw byte input, stream byte output.
// No dependencies.
`default_nettype none

interface lzc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface lzc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

/* src/lzc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzc_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 5120
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/lzc_ctrl.sv */
// Controller of the compressor: sequences header, hash probes, code writes, padding,
// flush and table clearing. Depends on lzc_pkg.
`default_nettype none

module lzc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lzc_pkg::lzc_stat_t stat,
  output lzc_pkg::lzc_cmd_t      cmd
);
  import lzc_pkg::*;

  lzc_state_t state_r, state_nxt;
  logic [1:0] hdr_cnt_r, hdr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_SWEEP;
      hdr_cnt_r <= HDR_MAGIC0;
    end else begin
      state_r   <= state_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    hdr_cnt_nxt = hdr_cnt_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.hdr_sel = hdr_cnt_r;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = stat.last ? ST_FINAL : ST_DRAIN;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept  = 1'b1;
          hdr_cnt_nxt = HDR_MAGIC0;
          state_nxt   = stat.started ? ST_PROBE : ST_HDR;
        end
      end
      ST_HDR: begin
        if (stat.out_free) begin
          cmd.emit_hdr = 1'b1;
          if (hdr_cnt_r == HDR_FLAGS) begin
            hdr_cnt_nxt = HDR_MAGIC0;
            state_nxt   = stat.last ? ST_FINAL : ST_IDLE;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end
        end
      end
      ST_PROBE: begin
        priority if (stat.hit) begin
          cmd.take_code = 1'b1;
          state_nxt     = stat.last ? ST_FINAL : ST_IDLE;
        end else if (stat.miss) begin
          state_nxt = ST_PUT_PREFIX;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      ST_PUT_PREFIX: begin
        if (stat.acc_full) begin
          cmd.drain = stat.out_free;
        end else begin
          cmd.put_code = 1'b1;
          cmd.code_sel = CODE_PREFIX;
          state_nxt    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.miss_update = 1'b1;
        priority if (stat.dict_full) begin
          state_nxt = ST_PUT_CLEAR;
        end else begin
          state_nxt = stat.last ? ST_FINAL : ST_DRAIN;
        end
      end
      ST_PUT_CLEAR: begin
        if (stat.acc_full) begin
          cmd.drain = stat.out_free;
        end else begin
          cmd.put_code = 1'b1;
          cmd.code_sel = CODE_CLEAR;
          state_nxt    = ST_PAD;
        end
      end
      ST_PAD: begin
        priority if (stat.acc_full) begin
          cmd.drain = stat.out_free;
        end else if (!stat.pad_done) begin
          cmd.pad_step = 1'b1;
        end else begin
          cmd.clear_dict = 1'b1;
          cmd.take_byte  = 1'b1;
          priority if (stat.epoch_wrap) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = stat.last ? ST_FINAL : ST_DRAIN;
          end
        end
      end
      ST_FINAL: begin
        if (stat.acc_full) begin
          cmd.drain = stat.out_free;
        end else begin
          cmd.put_code = 1'b1;
          cmd.code_sel = CODE_PREFIX;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.fin_mode = 1'b1;
        priority if (stat.acc_full) begin
          cmd.drain = stat.out_free;
        end else if (!stat.acc_empty) begin
          cmd.flush = stat.out_free;
        end else begin
          cmd.clear_dict = 1'b1;
          cmd.msg_reset  = 1'b1;
          state_nxt      = stat.epoch_wrap ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (stat.acc_full) begin
          cmd.drain = stat.out_free;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

endmodule

`default_nettype wire

/* src/lzc_dp.sv */
// Datapath of the compressor: message state, hash probe address, table RAM, bit
// packer and output register. Depends on lzc_pkg, lzc_ram.
`default_nettype none

module lzc_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_message,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  input  wire lzc_pkg::lzc_cmd_t  cmd,
  output lzc_pkg::lzc_stat_t     stat
);
  import lzc_pkg::*;

  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              started_r, started_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] step_r, step_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [12:0]       nfc_r, nfc_nxt;
  logic [4:0]        phase_r, phase_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [6:0]        pad_r, pad_nxt;
  logic [TAG_W-1:0]  epoch_r, epoch_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  logic [ADDR_W-1:0] home;
  logic [ADDR_W-1:0] adv;
  logic [WORD_W-1:0] rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic              tag_ok;
  logic [CODE_W-1:0] code_v;
  logic [CODE_W-1:0] code_m;
  logic [4:0]        phase_sum;
  logic [12:0]       top_code;
  logic [6:0]        pad_k;

  lzc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HASH_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt),
    .rdata (rdata)
  );

  assign home      = {1'b0, in_data_byte, 4'b0000} ^ {1'b0, prefix_r};
  assign adv       = (idx_r >= step_r) ? (idx_r - step_r) : ((PROBE_MOD - step_r) + idx_r);
  assign tag_ok    = rdata[WORD_W-1:32] == epoch_r;
  assign code_v    = (cmd.code_sel == CODE_CLEAR) ? DICT_RESET_CODE : prefix_r;
  assign code_m    = code_v & ~(12'hFFF << cw_r);
  assign phase_sum = phase_r + {1'b0, cw_r};
  assign top_code  = ~(13'h1FFF << cw_r);
  assign pad_k     = (pad_r >= 7'd8) ? 7'd8 : pad_r;

  always_comb begin
    stat.started    = started_r;
    stat.last       = last_r;
    stat.hit        = tag_ok && !rdata[31] && (rdata[31:12] == {prefix_r, byte_r});
    stat.miss       = !tag_ok;
    stat.acc_full   = cnt_r >= 5'd8;
    stat.acc_empty  = cnt_r == 5'd0;
    stat.out_free   = !ovalid_r || out_ready;
    stat.pad_done   = pad_r == 7'd0;
    stat.dict_full  = nfc_r[12];
    stat.epoch_wrap = epoch_r == TAG_LAST;
    stat.sweep_last = sweep_r == SWEEP_LAST;
  end

  always_comb begin
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    started_nxt = started_r;
    prefix_nxt  = prefix_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    cw_nxt      = cw_r;
    nfc_nxt     = nfc_r;
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    pad_nxt     = pad_r;
    epoch_nxt   = epoch_r;
    sweep_nxt   = sweep_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = {epoch_r, prefix_r, byte_r, nfc_r[CODE_W-1:0]};

    if (cmd.accept) begin
      byte_nxt = in_data_byte;
      last_nxt = in_end_of_message;
      idx_nxt  = home;
      step_nxt = (home == '0) ? ADDR_W'(1) : (PROBE_MOD - home);
      if (!started_r) begin
        prefix_nxt  = {4'b0000, in_data_byte};
        started_nxt = 1'b1;
      end
    end
    if (cmd.probe_step) begin
      idx_nxt = adv;
    end
    if (cmd.take_code) begin
      prefix_nxt = rdata[CODE_W-1:0];
    end
    if (cmd.put_code) begin
      acc_nxt   = acc_r | (ACC_W'(code_m) << cnt_r[2:0]);
      cnt_nxt   = cnt_r + {1'b0, cw_r};
      phase_nxt = phase_sum;
      pad_nxt   = pad_bits(phase_sum[4:2]);
    end
    if (cmd.miss_update) begin
      if ((nfc_r > top_code) && (cw_r < MAX_WIDTH)) begin
        cw_nxt = cw_r + 4'd1;
      end
      if (!nfc_r[12]) begin
        we         = 1'b1;
        nfc_nxt    = nfc_r + 13'd1;
        prefix_nxt = {4'b0000, byte_r};
      end
    end
    if (cmd.pad_step) begin
      cnt_nxt = cnt_r + pad_k[CNT_W-1:0];
      pad_nxt = pad_r - pad_k;
    end
    if (cmd.clear_dict) begin
      cw_nxt    = INIT_WIDTH;
      nfc_nxt   = FIRST_FREE;
      phase_nxt = '0;
      epoch_nxt = (epoch_r == TAG_LAST) ? TAG_FIRST : (epoch_r + 8'd1);
    end
    if (cmd.take_byte) begin
      prefix_nxt = {4'b0000, byte_r};
    end
    if (cmd.msg_reset) begin
      prefix_nxt  = '0;
      started_nxt = 1'b0;
      last_nxt    = 1'b0;
    end
    if (cmd.sweep) begin
      we        = 1'b1;
      waddr     = sweep_r;
      wdata     = '0;
      sweep_nxt = (sweep_r == SWEEP_LAST) ? '0 : (sweep_r + 13'd1);
    end
    if (cmd.emit_hdr) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = hdr_byte(cmd.hdr_sel);
      olast_nxt  = 1'b0;
    end
    if (cmd.drain) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = acc_r[7:0];
      olast_nxt  = cmd.fin_mode && (cnt_r == 5'd8);
      acc_nxt    = acc_r >> 8;
      cnt_nxt    = cnt_r - 5'd8;
    end
    if (cmd.flush) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = acc_r[7:0];
      olast_nxt  = 1'b1;
      acc_nxt    = '0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= 1'b0;
      started_r <= 1'b0;
      prefix_r  <= '0;
      cw_r      <= INIT_WIDTH;
      nfc_r     <= FIRST_FREE;
      phase_r   <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      pad_r     <= '0;
      epoch_r   <= TAG_FIRST;
      sweep_r   <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      last_r    <= last_nxt;
      started_r <= started_nxt;
      prefix_r  <= prefix_nxt;
      cw_r      <= cw_nxt;
      nfc_r     <= nfc_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      pad_r     <= pad_nxt;
      epoch_r   <= epoch_nxt;
      sweep_r   <= sweep_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    idx_r   <= idx_nxt;
    step_r  <= step_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

endmodule

`default_nettype wire

/* src/lzw_compress_hashed_12bit.sv */
// Top level of the hashed 12-bit LZW compressor (compress-style stream).
// Depends on lzc_pkg, lzc_ifs, lzc_ctrl, lzc_dp, lzc_ram.
//
//   beat     | dir | payload                         | last beat marks
//   in_bus   | in  | data_byte, end_of_message       | end of raw message
//   out_bus  | out | out_byte, out_last              | final stream byte
//
// Each byte is accepted, then hash probes run through the RAM read port; a miss adds
// the prefix code write and table update, and output beats drain from the bit packer.
// A table clear adds padding steps to the bit packer.
// After reset, and after every 255 table clears (each message end is one), a
// clearing pass runs through all 5120 table RAM entries before the next byte is taken.
// A stalled out_bus holds the block in any step that must emit a byte; nothing is dropped.
`default_nettype none

module lzw_compress_hashed_12bit (
  input wire logic  clk,
  input wire logic  rst_n,
  lzc_in_if.sink    in_bus,
  lzc_out_if.source out_bus
);
  import lzc_pkg::*;

  lzc_cmd_t  cmd;
  lzc_stat_t stat;
  logic      in_ready;

  lzc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_bus.data_byte),
    .in_end_of_message (in_bus.end_of_message),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_byte          (out_bus.out_byte),
    .out_last          (out_bus.out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

  assign in_bus.ready = in_ready;

endmodule

`default_nettype wire
